/* rtl/core/plin_pkg.sv */
// package for the positional list block: codes, state type and the
// command/status structs between controller and datapath
// no dependencies
`default_nettype none

package plin_pkg;

  localparam int DEF_CAPACITY = 128;

  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_PLACE,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic setup;    // latch status, load scan pointer and end
    logic scan;     // read store at pointer, step pointer
    logic finish;   // close out a delete (count down)
    logic place;    // write new value, count up
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;       // operation is legal
    logic skip;     // insert at the tail, nothing to move
    logic last;     // pointer sits on the final scan address
    logic is_ins;   // latched operation is an insert
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/plin_dp.sv */
// datapath of the positional list: element store, count, scan pointer,
// one-deep read/write pipeline for moving entries, result registers
// depends on plin_pkg
`default_nettype none

module plin_dp #(
  parameter int CAPACITY = plin_pkg::DEF_CAPACITY
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [plin_pkg::OP_W-1:0]           operation,
  input  wire logic [plin_pkg::POS_W-1:0]          position,
  input  wire logic signed [plin_pkg::DATA_W-1:0]  value,
  input  wire plin_pkg::cmd_t                      cmd,
  output plin_pkg::sts_t                           sts,
  output logic [plin_pkg::STAT_W-1:0]              status,
  output logic signed [plin_pkg::DATA_W-1:0]       element,
  output logic [plin_pkg::COUNT_W-1:0]             count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > plin_pkg::POS_W) ? CW : plin_pkg::POS_W) + 1;

  logic [plin_pkg::DATA_W-1:0] mem [CAPACITY];

  logic [plin_pkg::OP_W-1:0]    op_q;
  logic [plin_pkg::POS_W-1:0]   pos_q;
  logic [plin_pkg::DATA_W-1:0]  val_q;
  logic [CW-1:0]                cnt;
  logic [AW-1:0]                ptr;
  logic [AW-1:0]                end_q;
  logic                         first;
  logic                         pend;
  logic [AW-1:0]                pend_addr;
  logic                         pend_wr;
  logic                         pend_cap;
  logic [plin_pkg::DATA_W-1:0]  rd_data;
  logic [plin_pkg::STAT_W-1:0]  status_q;
  logic [plin_pkg::DATA_W-1:0]  element_q;

  logic [WW-1:0]                pos_w;
  logic [WW-1:0]                cnt_w;
  logic [WW-1:0]                pos_m1;
  logic [WW-1:0]                cnt_m1;
  logic                         pos_nz;
  logic                         ins_ok;
  logic                         rd_ok;
  logic                         full;
  logic                         is_ins;
  logic                         is_del;
  logic [plin_pkg::STAT_W-1:0]  status_c;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [plin_pkg::DATA_W-1:0]  mem_wd;

  always_comb begin
    pos_w  = WW'(pos_q);
    cnt_w  = WW'(cnt);
    pos_m1 = pos_w - WW'(1);
    cnt_m1 = cnt_w - WW'(1);
    pos_nz = (pos_q != '0);
    ins_ok = pos_nz && (pos_w <= cnt_w + WW'(1));
    rd_ok  = pos_nz && (pos_w <= cnt_w);
    full   = (cnt_w >= WW'(CAPACITY));
    is_ins = (op_q == plin_pkg::OP_INSERT);
    is_del = (op_q == plin_pkg::OP_DELETE);
  end

  always_comb begin
    unique case (op_q)
      plin_pkg::OP_INSERT: begin
        if (!ins_ok) begin
          status_c = plin_pkg::ST_RANGE;
        end else if (full) begin
          status_c = plin_pkg::ST_FULL;
        end else begin
          status_c = plin_pkg::ST_OK;
        end
      end
      plin_pkg::OP_DELETE, plin_pkg::OP_READ: begin
        status_c = rd_ok ? plin_pkg::ST_OK : plin_pkg::ST_RANGE;
      end
      default: begin
        status_c = plin_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    sts.ok     = (status_c == plin_pkg::ST_OK);
    sts.skip   = is_ins && (pos_w == cnt_w + WW'(1));
    sts.last   = (ptr == end_q);
    sts.is_ins = is_ins;
  end

  // store write port: new value on place, else the pending move
  always_comb begin
    mem_we = cmd.place || (pend && pend_wr);
    mem_wa = cmd.place ? pos_m1[AW-1:0] : pend_addr;
    mem_wd = cmd.place ? val_q : rd_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.scan) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.scan;
      if (cmd.place) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.finish && is_del) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      pos_q <= position;
      val_q <= value;
    end
    if (cmd.setup) begin
      status_q  <= status_c;
      element_q <= '0;
      first     <= 1'b1;
      ptr       <= is_ins ? cnt_m1[AW-1:0] : pos_m1[AW-1:0];
      end_q     <= is_del ? cnt_m1[AW-1:0] : pos_m1[AW-1:0];
    end
    if (cmd.scan) begin
      first     <= 1'b0;
      ptr       <= is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
      pend_addr <= is_ins ? (ptr + AW'(1)) : (ptr - AW'(1));
      pend_wr   <= is_ins || (is_del && !first);
      pend_cap  <= !is_ins && first;
    end
    if (pend && pend_cap) begin
      element_q <= rd_data;
    end
  end

  assign status  = status_q;
  assign element = element_q;
  assign count   = plin_pkg::COUNT_W'(cnt);

endmodule

`default_nettype wire

/* rtl/core/plin_ctrl.sv */
// controller of the positional list: sequences check, entry moves,
// placement and the result handshake
// depends on plin_pkg
`default_nettype none

module plin_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire plin_pkg::sts_t  sts,
  output plin_pkg::cmd_t       cmd
);

  plin_pkg::state_t state;
  plin_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plin_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      plin_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = plin_pkg::S_CHECK;
        end
      end
      plin_pkg::S_CHECK: begin
        if (!sts.ok) begin
          state_next = plin_pkg::S_RESP;
        end else if (sts.skip) begin
          state_next = plin_pkg::S_PLACE;
        end else begin
          state_next = plin_pkg::S_SCAN;
        end
      end
      plin_pkg::S_SCAN: begin
        if (sts.last) begin
          state_next = plin_pkg::S_DRAIN;
        end
      end
      plin_pkg::S_DRAIN: begin
        state_next = sts.is_ins ? plin_pkg::S_PLACE : plin_pkg::S_RESP;
      end
      plin_pkg::S_PLACE: begin
        state_next = plin_pkg::S_RESP;
      end
      plin_pkg::S_RESP: begin
        if (out_ready) begin
          state_next = plin_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plin_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      plin_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      plin_pkg::S_CHECK: begin
        cmd.setup = 1'b1;
      end
      plin_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      plin_pkg::S_DRAIN: begin
        cmd.finish = 1'b1;
      end
      plin_pkg::S_PLACE: begin
        cmd.place = 1'b1;
      end
      plin_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/positional_list_insert_delete.sv */
// top level of the positional list with insert, delete and read
// instantiates plin_ctrl and plin_dp, depends on plin_pkg
//
//   channel  handshake            payload
//   input    in_valid / in_ready  operation[1:0] position[7:0] value[31:0]
//   output   out_valid/out_ready  status[1:0] element[31:0] count[7:0]
//
// one item at a time; entries move one per cycle through the store's single
// read and single write port; insert moves entries at and above the position
// up, then writes the value (at once at the tail); delete moves later ones down
// rst (synchronous) empties the list; store contents need no clearing
// a result holds its registers until out_ready; no item is taken meanwhile
`default_nettype none

module positional_list_insert_delete #(
  parameter int CAPACITY = plin_pkg::DEF_CAPACITY
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [plin_pkg::OP_W-1:0]           operation,
  input  wire logic [plin_pkg::POS_W-1:0]          position,
  input  wire logic signed [plin_pkg::DATA_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [plin_pkg::STAT_W-1:0]              status,
  output logic signed [plin_pkg::DATA_W-1:0]       element,
  output logic [plin_pkg::COUNT_W-1:0]             count
);

  // command and status between sequencer and datapath
  plin_pkg::cmd_t cmd;
  plin_pkg::sts_t sts;

  // sequencer: accept, check, scan the store, place, present result
  plin_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: store, count, move pipeline and result registers
  plin_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .operation (operation),
    .position  (position),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .status    (status),
    .element   (element),
    .count     (count)
  );

  // a full status only shows when the list is at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == plin_pkg::ST_FULL) |->
      (count == plin_pkg::COUNT_W'(CAPACITY)))
    else $error("full status with list below capacity");

  // rejected items carry a zero element
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != plin_pkg::ST_OK) |-> (element == '0))
    else $error("nonzero element on rejected item");

  // never ready for input while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // a delivered result is not presented again
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire
